### src/assert_macros.svh
// assertion macros shared by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is low
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// clocked implication, disabled while reset is low
`define ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

### src/bda_pkg.sv
// types, constants and helper functions of the decimal ascii converter
`timescale 1ns / 1ps

package bda_pkg;

    localparam int NUM_W     = 32;
    localparam int CHAR_W    = 6;
    localparam int POS_W     = 4;
    localparam int DIG_W     = 4;
    localparam int MULT_W    = 34;
    localparam int MAX_POS   = 9;
    localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

    typedef struct packed {
        logic [NUM_W-1:0] number;
        logic [POS_W-1:0] top_pos;
    } work_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } back_state_t;

    // power of ten for a digit position
    function automatic logic [MULT_W-1:0] pow10(input logic [POS_W-1:0] p);
        logic [MULT_W-1:0] v;
        case (p)
            4'd0:    v = 34'd1;
            4'd1:    v = 34'd10;
            4'd2:    v = 34'd100;
            4'd3:    v = 34'd1000;
            4'd4:    v = 34'd10000;
            4'd5:    v = 34'd100000;
            4'd6:    v = 34'd1000000;
            4'd7:    v = 34'd10000000;
            4'd8:    v = 34'd100000000;
            4'd9:    v = 34'd1000000000;
            default: v = 34'd0;
        endcase
        return v;
    endfunction

endpackage

### src/bda_front.sv
// front end: accepts items and finds the position of the leading digit
`timescale 1ns / 1ps

module bda_front (
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [31:0]               number,
    input  bda_pkg::queue_stat_t      q_stat,
    output logic                      push,
    output bda_pkg::work_t            push_data
);
    import bda_pkg::*;

    logic [POS_W-1:0] top_pos;

    // highest position whose power of ten does not exceed the value
    always_comb
    begin
        top_pos = '0;
        for (int j = 1; j <= MAX_POS; j++)
        begin
            if ({2'b00, number} >= pow10(POS_W'(j)))
            begin
                top_pos = POS_W'(j);
            end
        end
    end

    assign in_ready          = !q_stat.full;
    assign push              = in_valid && !q_stat.full;
    assign push_data.number  = number;
    assign push_data.top_pos = top_pos;

endmodule

### src/bda_queue.sv
// two entry queue between front and back
`timescale 1ns / 1ps

module bda_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  bda_pkg::work_t        push_data,
    input  logic                  pop,
    output bda_pkg::work_t        pop_data,
    output bda_pkg::queue_stat_t  q_stat
);
    import bda_pkg::*;

    work_t      mem_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       do_push;
    logic       do_pop;

    assign q_stat.full  = (count_reg == 2'd2);
    assign q_stat.empty = (count_reg == 2'd0);
    assign do_push      = push && !q_stat.full;
    assign do_pop       = pop && !q_stat.empty;
    assign pop_data     = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### src/bda_back.sv
// back end: peels off one decimal digit per step, most significant first
`timescale 1ns / 1ps

module bda_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  bda_pkg::work_t        pop_data,
    input  bda_pkg::queue_stat_t  q_stat,
    output logic                  pop,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [5:0]            digit_char,
    output logic                  last_digit
);
    import bda_pkg::*;

    back_state_t        state_reg;
    back_state_t        state_next;
    logic [NUM_W-1:0]   rem_reg;
    logic [NUM_W-1:0]   rem_next;
    logic [POS_W-1:0]   pos_reg;
    logic [POS_W-1:0]   pos_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [CHAR_W-1:0]  digit_char_reg;
    logic               last_digit_reg;
    logic               step;
    logic               final_step;
    logic               load;
    logic [MULT_W-1:0]  pow;
    logic [MULT_W-1:0]  mult [10];
    logic [9:1]         ge;
    logic [DIG_W-1:0]   digit;

    // digit = number of multiples of the position weight that fit
    always_comb
    begin
        pow = pow10(pos_reg);
        for (int j = 0; j < 10; j++)
        begin
            mult[j] = pow * MULT_W'(j);
        end
        for (int j = 1; j < 10; j++)
        begin
            ge[j] = ({2'b00, rem_reg} >= mult[j]);
        end
        digit    = DIG_W'($countones(ge));
        rem_next = NUM_W'({2'b00, rem_reg} - mult[digit]);
    end

    assign step       = (state_reg == ST_RUN) && (!out_valid_reg || out_ready);
    assign final_step = step && (pos_reg == '0);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (final_step && q_stat.empty)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        pop = 1'b0;
        case (state_reg)
            ST_IDLE: pop = !q_stat.empty;
            ST_RUN:  pop = final_step && !q_stat.empty;
            default: pop = 1'b0;
        endcase
        load     = pop;
        pos_next = load ? pop_data.top_pos : pos_reg - POS_W'(1);
        if (step)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rem_reg <= pop_data.number;
            pos_reg <= pos_next;
        end
        else if (step)
        begin
            rem_reg <= rem_next;
            pos_reg <= pos_next;
        end
        if (step)
        begin
            digit_char_reg <= ASCII_ZERO + CHAR_W'(digit);
            last_digit_reg <= (pos_reg == '0);
        end
    end

    assign out_valid  = out_valid_reg;
    assign digit_char = digit_char_reg;
    assign last_digit = last_digit_reg;

endmodule

### src/binary_to_decimal_ascii.sv
// binary to decimal ascii converter: top level
// path of an item: front, queue, back end load, registered output stage
// throughput: one digit per cycle while out_ready allows, set by the single digit step
// unit in the back end; an item gives 1 to 10 digits
// reset: rst_n is asynchronous and clears the queue, the sequencer and the output valid
`timescale 1ns / 1ps

module binary_to_decimal_ascii (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] number,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [5:0]  digit_char,
    output logic        last_digit
);
    import bda_pkg::*;

    // links between the three parts
    queue_stat_t q_stat;
    work_t       push_data;
    work_t       pop_data;
    logic        push;
    logic        pop;

    // front: takes an item whenever the queue has room and works out
    // where the leading digit sits
    bda_front u_front (
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .number    (number),
        .q_stat    (q_stat),
        .push      (push),
        .push_data (push_data)
    );

    // queue: lets the front keep taking items while the back stalls
    bda_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .q_stat    (q_stat)
    );

    // back: one digit per step into a registered output stage,
    // picks up the next queued item on its final digit
    bda_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_data   (pop_data),
        .q_stat     (q_stat),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .digit_char (digit_char),
        .last_digit (last_digit)
    );

endmodule

### src/bda_checker.sv
// port level checks of the converter, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bda_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [5:0]  digit_char,
    input logic        last_digit
);
    logic       in_acc;
    logic       out_acc;
    logic       out_stall;
    logic       char_ok;
    logic       lead_zero;
    logic [6:0] pay;
    logic [2:0] open_reg;
    logic [3:0] run_reg;
    logic       start_reg;

    assign in_acc    = in_valid && in_ready;
    assign out_acc   = out_valid && out_ready;
    assign out_stall = out_valid && !out_ready;
    assign char_ok   = (digit_char >= 6'd48) && (digit_char <= 6'd57);
    assign lead_zero = start_reg && (digit_char == 6'd48);
    assign pay       = {digit_char, last_digit};

    // items taken whose last digit has not gone out, and digits of the current run
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg  <= 3'd0;
            run_reg   <= 4'd0;
            start_reg <= 1'b1;
        end
        else
        begin
            open_reg <= open_reg + 3'(in_acc) - 3'(out_acc && last_digit);
            if (out_acc)
            begin
                run_reg   <= last_digit ? 4'd0 : run_reg + 4'd1;
                start_reg <= last_digit;
            end
        end
    end

    `ASSERT_IMP(a_char_range, clk, rst_n, out_valid, char_ok, "digit out of range")
    `ASSERT_IMP(a_no_lead_zero, clk, rst_n, out_valid && lead_zero, last_digit, "leading zero")
    `ASSERT_IMP(a_run_len, clk, rst_n, out_valid, run_reg <= 4'd9, "run over ten digits")
    `ASSERT_IMP(a_no_orphan, clk, rst_n, out_valid, open_reg != 3'd0, "digit without an item")
    `ASSERT_CLK(a_out_hold, clk, rst_n, out_stall |=> out_valid && $stable(pay), "held digit changed")

endmodule

bind binary_to_decimal_ascii bda_checker u_bda_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .digit_char (digit_char),
    .last_digit (last_digit)
);
